[hw/rtl/ordered_char_list_engine_assert.svh]
// Assertion macros shared by the ordered list engine RTL.
// Each macro expects a clock named clk and a reset named rst in the using scope.
`ifndef ORDERED_CHAR_LIST_ENGINE_ASSERT_SVH
`define ORDERED_CHAR_LIST_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OCLE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OCLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/ocle_pkg.sv]
// Shared types and codes for the ordered list engine.
// No dependencies; used by ordered_char_list_engine.
package ocle_pkg;

  // Operation kinds carried by an input item.
  localparam logic [2:0] KIND_INS_SORTED = 3'd0;
  localparam logic [2:0] KIND_INS_BACK   = 3'd1;
  localparam logic [2:0] KIND_INS_FRONT  = 3'd2;
  localparam logic [2:0] KIND_DEL_VALUE  = 3'd3;
  localparam logic [2:0] KIND_REM_FRONT  = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_OPEN_RD,
    S_OPEN_WR,
    S_PUT,
    S_TAKE_RD,
    S_TAKE_CAP,
    S_CLOSE_RD,
    S_CLOSE_WR,
    S_FRONT_RD,
    S_FRONT_CAP,
    S_DONE
  } state_t;

endpackage

[hw/rtl/ocle_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used by ordered_char_list_engine for list storage.
module ocle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/ordered_char_list_engine.sv]
// Ordered byte list engine: one result item per request item.
// Depends on ocle_pkg, ocle_ram and ordered_char_list_engine_assert.svh.
// Full, empty and ignored requests go straight to reading the front entry for the result; an
// insert at the back writes its entry first; a search or shift steps through the list RAM one
// entry at a time, with two states for each entry. The next item is accepted the cycle after the
// result is taken. Reset empties the list (count zero); the storage itself is not cleared.
`include "ordered_char_list_engine_assert.svh"

module ordered_char_list_engine #(
  parameter int CAPACITY = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] kind,
  input  logic [7:0] value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] status,
  output logic [7:0] removed_value,
  output logic [4:0] entry_count,
  output logic [7:0] front_value
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  ocle_pkg::state_t state, state_next;

  logic [2:0]    op_kind;
  logic [7:0]    op_value;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] pos, pos_next;
  logic [CW-1:0] idx, idx_next;
  logic [1:0]    status_next;
  logic [7:0]    removed_next;
  logic [7:0]    front_next;
  logic [CW-1:0] idx_p1;
  logic [CW-1:0] idx_m1;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  // List storage, in list order with the front entry at address zero.
  ocle_ram #(
    .WIDTH(8),
    .DEPTH(CAPACITY)
  ) u_list_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign idx_p1      = idx + CW'(1);
  assign idx_m1      = idx - CW'(1);
  assign in_stall    = (state != ocle_pkg::S_IDLE);
  assign out_valid   = (state == ocle_pkg::S_DONE);
  assign entry_count = 5'(count);

  // State and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ocle_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Item and result payload registers.
  always_ff @(posedge clk) begin
    if (state == ocle_pkg::S_IDLE && in_valid) begin
      op_kind  <= kind;
      op_value <= value;
    end
    pos           <= pos_next;
    idx           <= idx_next;
    status        <= status_next;
    removed_value <= removed_next;
    front_value   <= front_next;
  end

  // Sequencer: search, shift and write steps, one RAM access each.
  always_comb begin
    state_next   = state;
    count_next   = count;
    pos_next     = pos;
    idx_next     = idx;
    status_next  = status;
    removed_next = removed_value;
    front_next   = front_value;
    mem_we       = 1'b0;
    mem_waddr    = idx[AW-1:0];
    mem_wdata    = mem_rdata;
    mem_raddr    = idx[AW-1:0];

    case (state)
      ocle_pkg::S_IDLE: begin
        if (in_valid) begin
          status_next  = ocle_pkg::ST_OK;
          removed_next = '0;
          state_next   = ocle_pkg::S_DECIDE;
        end
      end

      // Pick the walk that the operation kind needs.
      ocle_pkg::S_DECIDE: begin
        case (op_kind)
          ocle_pkg::KIND_INS_SORTED, ocle_pkg::KIND_INS_BACK, ocle_pkg::KIND_INS_FRONT: begin
            if (count == CW'(CAPACITY)) begin
              status_next = ocle_pkg::ST_FULL;
              state_next  = ocle_pkg::S_FRONT_RD;
            end else if (op_kind == ocle_pkg::KIND_INS_SORTED) begin
              idx_next   = '0;
              state_next = ocle_pkg::S_SRCH_RD;
            end else if (op_kind == ocle_pkg::KIND_INS_BACK) begin
              pos_next   = count;
              state_next = ocle_pkg::S_PUT;
            end else begin
              pos_next   = '0;
              idx_next   = count;
              state_next = ocle_pkg::S_OPEN_RD;
            end
          end
          ocle_pkg::KIND_DEL_VALUE, ocle_pkg::KIND_REM_FRONT: begin
            if (count == '0) begin
              status_next = ocle_pkg::ST_EMPTY;
              state_next  = ocle_pkg::S_FRONT_RD;
            end else if (op_kind == ocle_pkg::KIND_REM_FRONT) begin
              state_next = ocle_pkg::S_TAKE_RD;
            end else begin
              idx_next   = '0;
              state_next = ocle_pkg::S_SRCH_RD;
            end
          end
          default: begin
            state_next = ocle_pkg::S_FRONT_RD;
          end
        endcase
      end

      // Linear search: read one entry, compare it in the next cycle.
      ocle_pkg::S_SRCH_RD: begin
        if (idx == count) begin
          if (op_kind == ocle_pkg::KIND_INS_SORTED) begin
            pos_next   = count;
            state_next = ocle_pkg::S_PUT;
          end else begin
            status_next = ocle_pkg::ST_NOT_FOUND;
            state_next  = ocle_pkg::S_FRONT_RD;
          end
        end else begin
          state_next = ocle_pkg::S_SRCH_CMP;
        end
      end

      ocle_pkg::S_SRCH_CMP: begin
        if (op_kind == ocle_pkg::KIND_INS_SORTED) begin
          if (op_value <= mem_rdata) begin
            pos_next   = idx;
            idx_next   = count;
            state_next = ocle_pkg::S_OPEN_RD;
          end else begin
            idx_next   = idx_p1;
            state_next = ocle_pkg::S_SRCH_RD;
          end
        end else begin
          if (op_value == mem_rdata) begin
            removed_next = op_value;
            state_next   = ocle_pkg::S_CLOSE_RD;
          end else begin
            idx_next   = idx_p1;
            state_next = ocle_pkg::S_SRCH_RD;
          end
        end
      end

      // Open a gap at pos by moving entries one place toward the back.
      ocle_pkg::S_OPEN_RD: begin
        mem_raddr = idx_m1[AW-1:0];
        if (idx == pos) begin
          state_next = ocle_pkg::S_PUT;
        end else begin
          state_next = ocle_pkg::S_OPEN_WR;
        end
      end

      ocle_pkg::S_OPEN_WR: begin
        mem_we     = 1'b1;
        idx_next   = idx_m1;
        state_next = ocle_pkg::S_OPEN_RD;
      end

      ocle_pkg::S_PUT: begin
        mem_we     = 1'b1;
        mem_waddr  = pos[AW-1:0];
        mem_wdata  = op_value;
        count_next = count + CW'(1);
        state_next = ocle_pkg::S_FRONT_RD;
      end

      // Fetch the front entry for a remove-front.
      ocle_pkg::S_TAKE_RD: begin
        mem_raddr  = '0;
        state_next = ocle_pkg::S_TAKE_CAP;
      end

      ocle_pkg::S_TAKE_CAP: begin
        removed_next = mem_rdata;
        idx_next     = '0;
        state_next   = ocle_pkg::S_CLOSE_RD;
      end

      // Close the gap at idx by moving later entries one place forward.
      ocle_pkg::S_CLOSE_RD: begin
        mem_raddr = idx_p1[AW-1:0];
        if (idx_p1 >= count) begin
          count_next = count - CW'(1);
          state_next = ocle_pkg::S_FRONT_RD;
        end else begin
          state_next = ocle_pkg::S_CLOSE_WR;
        end
      end

      ocle_pkg::S_CLOSE_WR: begin
        mem_we     = 1'b1;
        idx_next   = idx_p1;
        state_next = ocle_pkg::S_CLOSE_RD;
      end

      // Read the front entry for the result.
      ocle_pkg::S_FRONT_RD: begin
        mem_raddr  = '0;
        state_next = ocle_pkg::S_FRONT_CAP;
      end

      ocle_pkg::S_FRONT_CAP: begin
        front_next = (count == '0) ? 8'd0 : mem_rdata;
        state_next = ocle_pkg::S_DONE;
      end

      ocle_pkg::S_DONE: begin
        if (!out_stall) begin
          state_next = ocle_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = ocle_pkg::S_IDLE;
      end
    endcase
  end

  // Checks on the sequencer and the entry count.
  `OCLE_ASSERT_SAME(a_count_bound, 1'b1, count <= CW'(CAPACITY),
    "entry count exceeds capacity")
  `OCLE_ASSERT_SAME(a_full_status, out_valid && status == ocle_pkg::ST_FULL,
    count == CW'(CAPACITY), "full status reported on a list with room")
  `OCLE_ASSERT_SAME(a_empty_status, out_valid && status == ocle_pkg::ST_EMPTY,
    count == '0, "empty status reported on a list with entries")
  `OCLE_ASSERT_NEXT(a_accept_decide, in_valid && !in_stall,
    state == ocle_pkg::S_DECIDE, "accepted item did not start decoding")

endmodule
